// ----- src/box_filter_3x3_edge_average_top_macros.svh -----
// Assertion macros for the box filter block.
`ifndef BOX_FILTER_3X3_EDGE_AVERAGE_TOP_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AVERAGE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define BFEA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
// Condition must never be seen outside reset
`define BFEA_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define BFEA_ASSERT(lbl, clk, rstn, prop)
`define BFEA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- src/bfea_pkg.sv -----
`default_nettype none

package bfea_pkg;

  // Geometry
  localparam int unsigned MAX_SIZE = 1024;
  localparam int unsigned POS_W    = $clog2(MAX_SIZE);
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned PIX_W    = 8;

  // Neighbourhood sum of up to nine pixels
  localparam int unsigned SUM_W = $clog2(9 * 255 + 1);

  // Division by 4, 6 or 9 as multiply by a scaled reciprocal
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 15;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  // Results one pixel can release: above-left, left, above, own
  localparam int unsigned NUM_RES = 4;
  localparam int unsigned RES_IW  = $clog2(NUM_RES);

  // Output beat layout
  localparam int unsigned OUT_USED_W  = PIX_W + 2 * POS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    DIV_4 = 2'd0,
    DIV_6 = 2'd1,
    DIV_9 = 2'd2
  } div_e;

  // One window column, index 0 is the oldest row
  typedef logic [2:0][PIX_W-1:0] column_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_e             div;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } result_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last_row;
    logic             last_col;
  } s1_t;

  // Divisor from the number of neighbourhood rows and columns that lie in the image
  function automatic div_e div_of(logic three_rows, logic three_cols);
    div_e d;
    if (three_rows && three_cols) begin
      d = DIV_9;
    end else if (three_rows || three_cols) begin
      d = DIV_6;
    end else begin
      d = DIV_4;
    end
    return d;
  endfunction

  // ceil(2^16 / d); exact for every sum up to nine full-scale pixels
  function automatic logic [RECIP_W-1:0] recip(div_e d);
    logic [RECIP_W-1:0] r;
    r = '0;
    unique case (d)
      DIV_4:   r = RECIP_W'(16384);
      DIV_6:   r = RECIP_W'(10923);
      DIV_9:   r = RECIP_W'(7282);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/box_filter_3x3_edge_average_top.sv -----
// 3x3 box filter with edge averaging over a square image of image_size x image_size
// pixels (2..1024, values outside clamp) fed in raster order, one 8-bit pixel per beat.
// Each result is the truncated mean of the in-image 3x3 neighbourhood (divisor 4 at a
// corner, 6 on an edge, 9 inside), tagged with its row and column; pixel (r,c) is
// released when pixel (r+1,c+1) arrives, in the final row the results of the last two
// rows come out together, and the last result of the image carries tlast. The two
// previous rows live in one 1024 x 16-bit line memory, read on acceptance and written
// back as the pixel leaves the first stage. The input takes one pixel per cycle unless
// held by back-pressure; the output port passes one result per cycle while ready, so
// where a pixel releases two results (final row past column 0, and last column; four on
// the last pixel), the input slows. A pixel's first result passes the stage-1, stage-2
// and output registers. The line memory needs no clearing after reset; writing image_size
// restarts the image at row 0, column 0 and must only happen while the block is idle.
`default_nettype none

`include "box_filter_3x3_edge_average_top_macros.svh"

module box_filter_3x3_edge_average_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // image_size write
  input  logic                                 cfg_we_i,
  input  logic [bfea_pkg::SIZE_W-1:0]          cfg_wdata_i,
  // pixel input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bfea_pkg::PIX_W-1:0]           s_axis_tdata,  // [7:0] pixel
  // result output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] smoothed, [17:8] out_row, [27:18] out_column, zero above
  output logic [bfea_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast   // end_of_image
);

  localparam int unsigned PW = bfea_pkg::PIX_W;
  localparam int unsigned QW = bfea_pkg::POS_W;
  localparam int unsigned SW = bfea_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic [QW-1:0]             last_q;          // effective size minus one
  logic [QW-1:0]             row_q, col_q;
  logic                      in_fire;

  logic [2*PW-1:0]           line_mem [bfea_pkg::MAX_SIZE];
  logic [2*PW-1:0]           rd_q;            // {older, recent}
  logic                      mem_we;

  logic                      s1_valid_q;
  bfea_pkg::s1_t             s1_q;
  logic                      s1_has;
  logic                      s1_fire;

  bfea_pkg::column_t         wina_q, winb_q;  // oldest and newest stored columns
  bfea_pkg::column_t         newc;

  logic                      s2_valid_q;
  logic [bfea_pkg::NUM_RES-1:0] s2_mask_q;
  bfea_pkg::result_t         s2_res_q [bfea_pkg::NUM_RES];
  bfea_pkg::result_t         res_d    [bfea_pkg::NUM_RES];
  logic [bfea_pkg::NUM_RES-1:0] mask_d;
  logic [bfea_pkg::RES_IW-1:0]  pick;
  logic [bfea_pkg::NUM_RES-1:0] remain;
  logic                      s2_last;
  logic                      s2_pop;
  logic                      s2_load_ok;

  logic                      out_load;
  logic                      out_valid_q;
  logic [PW-1:0]             out_pix_q;
  logic [QW-1:0]             out_row_q, out_col_q;
  logic                      out_eoi_q;
  logic                      out_at_end;
  bfea_pkg::result_t         sel;
  logic [bfea_pkg::PROD_W-1:0] prod;

  // ---------------------------------------------------------------------------
  // Size register and raster position
  // ---------------------------------------------------------------------------
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= QW'(9);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < bfea_pkg::SIZE_W'(2)) begin
        last_q <= QW'(1);
      end else if (cfg_wdata_i > bfea_pkg::SIZE_W'(bfea_pkg::MAX_SIZE)) begin
        last_q <= QW'(bfea_pkg::MAX_SIZE - 1);
      end else begin
        last_q <= QW'(cfg_wdata_i - bfea_pkg::SIZE_W'(1));
      end
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      if (col_q == last_q) begin
        col_q <= '0;
        row_q <= (row_q == last_q) ? '0 : row_q + QW'(1);
      end else begin
        col_q <= col_q + QW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: read on acceptance, write back when stage 1 moves on.
  // Consecutive pixels never share a column, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  assign mem_we = s1_fire;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= line_mem[col_q];
    end
    if (mem_we) begin
      line_mem[s1_q.col] <= {rd_q[PW-1:0], s1_q.px};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pixel with its position
  // ---------------------------------------------------------------------------
  assign s1_has        = (s1_q.row != '0) && (s1_q.col != '0);
  assign s1_fire       = s1_valid_q && (!s1_has || s2_load_ok);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.px       <= s_axis_tdata;
      s1_q.row      <= row_q;
      s1_q.col      <= col_q;
      s1_q.last_row <= (row_q == last_q);
      s1_q.last_col <= (col_q == last_q);
    end
  end

  // New window column: two rows above from memory, current pixel below
  assign newc[0] = rd_q[2*PW-1:PW];
  assign newc[1] = rd_q[PW-1:0];
  assign newc[2] = s1_q.px;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      wina_q <= winb_q;
      winb_q <= newc;
    end
  end

  // Neighbourhood sums over the shifted window (wina, winb, newc)
  always_comb begin
    logic [SW-1:0] pa, pb, pc;     // lower two rows of each column
    logic [SW-1:0] ca, cb, cc;     // rows that lie in the image
    logic          top3, left3;
    pa    = SW'(wina_q[1]) + SW'(wina_q[2]);
    pb    = SW'(winb_q[1]) + SW'(winb_q[2]);
    pc    = SW'(newc[1])   + SW'(newc[2]);
    top3  = (s1_q.row != QW'(1));
    left3 = (s1_q.col != QW'(1));
    ca    = top3 ? pa + SW'(wina_q[0]) : pa;
    cb    = top3 ? pb + SW'(winb_q[0]) : pb;
    cc    = top3 ? pc + SW'(newc[0])   : pc;

    // above-left
    res_d[0].sum = cb + cc + (left3 ? ca : '0);
    res_d[0].div = bfea_pkg::div_of(top3, left3);
    res_d[0].row = s1_q.row - QW'(1);
    res_d[0].col = s1_q.col - QW'(1);
    // left, final row only
    res_d[1].sum = pb + pc + (left3 ? pa : '0);
    res_d[1].div = bfea_pkg::div_of(1'b0, left3);
    res_d[1].row = s1_q.row;
    res_d[1].col = s1_q.col - QW'(1);
    // above, right edge only
    res_d[2].sum = cb + cc;
    res_d[2].div = bfea_pkg::div_of(top3, 1'b0);
    res_d[2].row = s1_q.row - QW'(1);
    res_d[2].col = s1_q.col;
    // own pixel, bottom-right corner only
    res_d[3].sum = pb + pc;
    res_d[3].div = bfea_pkg::DIV_4;
    res_d[3].row = s1_q.row;
    res_d[3].col = s1_q.col;

    mask_d = {s1_q.last_row && s1_q.last_col, s1_q.last_col, s1_q.last_row, 1'b1};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: bundle of pending results, drained lowest first
  // ---------------------------------------------------------------------------
  always_comb begin
    pick = '0;
    for (int i = bfea_pkg::NUM_RES - 1; i >= 0; i--) begin
      if (s2_mask_q[i]) begin
        pick = bfea_pkg::RES_IW'(i);
      end
    end
    remain = s2_mask_q & ~(bfea_pkg::NUM_RES'(1) << pick);
  end

  assign s2_last    = (remain == '0);
  assign out_load   = !out_valid_q || m_axis_tready;
  assign s2_pop     = s2_valid_q && out_load;
  assign s2_load_ok = !s2_valid_q || (s2_pop && s2_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_mask_q  <= '0;
    end else if (s1_fire && s1_has) begin
      s2_valid_q <= 1'b1;
      s2_mask_q  <= mask_d;
    end else if (s2_pop) begin
      s2_mask_q <= remain;
      if (s2_last) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_has) begin
      for (int i = 0; i < bfea_pkg::NUM_RES; i++) begin
        s2_res_q[i] <= res_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: reciprocal multiply divides the selected sum
  // ---------------------------------------------------------------------------
  assign sel  = s2_res_q[pick];
  assign prod = bfea_pkg::PROD_W'(sel.sum) * bfea_pkg::PROD_W'(bfea_pkg::recip(sel.div));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_pop) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_pop) begin
      out_pix_q <= prod[bfea_pkg::RECIP_SHIFT +: PW];
      out_row_q <= sel.row;
      out_col_q <= sel.col;
      out_eoi_q <= (pick == bfea_pkg::RES_IW'(bfea_pkg::NUM_RES - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_eoi_q;
  assign m_axis_tdata  = {{(bfea_pkg::OUT_TDATA_W - bfea_pkg::OUT_USED_W){1'b0}},
                          out_col_q, out_row_q, out_pix_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // output beat sits on the bottom-right corner
  assign out_at_end = (out_row_q == last_q) && (out_col_q == last_q);

  `BFEA_ASSERT(a_s2_not_empty, clk_i, rst_ni, s2_valid_q |-> (s2_mask_q != '0))
  `BFEA_NEVER(a_mem_same_col, clk_i, rst_ni, mem_we && in_fire && (s1_q.col == col_q))
  `BFEA_ASSERT(a_eoi_corner, clk_i, rst_ni, (out_valid_q && out_eoi_q) |-> out_at_end)
  `BFEA_ASSERT(a_s1_stall_blocks, clk_i, rst_ni, (s1_valid_q && !s1_fire) |-> !s_axis_tready)

endmodule

`default_nettype wire

// ----- bench/tb_box_filter_3x3_edge_average_top.sv -----
`timescale 1ns / 100ps

module tb_box_filter_3x3_edge_average_top;

  localparam int PIX_W       = bfea_pkg::PIX_W;
  localparam int POS_W       = bfea_pkg::POS_W;
  localparam int SIZE_W      = bfea_pkg::SIZE_W;
  localparam int MAX_SIZE    = bfea_pkg::MAX_SIZE;
  localparam int OUT_TDATA_W = bfea_pkg::OUT_TDATA_W;

  localparam int ROW_LSB     = PIX_W;
  localparam int COL_LSB     = PIX_W + POS_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  // one smoothed pixel as it should leave the block
  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             eoi;
  } mean_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  box_filter_3x3_edge_average_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // pixels waiting to be offered, and smoothed pixels still owed by the block
  logic [PIX_W-1:0] pixel_q [$];
  mean_t            pending_means [$];

  int pixels_pushed = 0;
  int pixels_taken  = 0;
  int mismatch_count = 0;
  int cycle_count   = 0;
  int tx_idle_pct   = 20;
  int rx_idle_pct   = 81;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int rand_sent     = 0;
  bit in_taken      = 1'b0;

  // model of the block: image size, raster position, two line stores, 3x3 window
  logic [SIZE_W-1:0] size_reg;
  int unsigned       next_row;
  int unsigned       next_col;
  logic [PIX_W-1:0]  line_two_up [MAX_SIZE];
  logic [PIX_W-1:0]  line_one_up [MAX_SIZE];
  logic [PIX_W-1:0]  win [3][3];  // [col-2, col-1, col][row-2, row-1, row]

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // truncated mean over window columns c0..2, rows r0..2
  function automatic int unsigned block_mean(int r0, int c0);
    int unsigned acc;
    int unsigned cnt;
    acc = 0;
    cnt = 0;
    for (int c = c0; c < 3; c++) begin
      for (int r = r0; r < 3; r++) begin
        acc += win[c][r];
        cnt++;
      end
    end
    return acc / cnt;
  endfunction

  task automatic push_mean(input int unsigned m, input int unsigned r, input int unsigned c,
                           input bit eoi);
    mean_t e;
    e.smoothed = PIX_W'(m);
    e.row      = POS_W'(r);
    e.column   = POS_W'(c);
    e.eoi      = eoi;
    pending_means.push_back(e);
  endtask

  // take one pixel into the window and queue the smoothed pixels it releases
  task automatic advance_window(input logic [PIX_W-1:0] px);
    int unsigned n;
    int unsigned row;
    int unsigned col;
    int          r0;
    int          c0;
    bit          last_row;
    n = (size_reg < 2) ? 2 : (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
    row = next_row;
    col = next_col;
    if (row >= n || col >= n) begin
      row = 0;
      col = 0;
    end
    last_row = (row == n - 1);
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = line_two_up[col];
    win[2][1] = line_one_up[col];
    win[2][2] = px;
    line_two_up[col] = line_one_up[col];
    line_one_up[col] = px;
    if (row >= 1 && col >= 1) begin
      // top row and left column have no neighbours above / to the left
      r0 = (row > 1) ? 0 : 1;
      c0 = (col > 1) ? 0 : 1;
      push_mean(block_mean(r0, c0), row - 1, col - 1, 1'b0);
      if (last_row) push_mean(block_mean(1, c0), row, col - 1, 1'b0);
      if (col == n - 1) begin
        push_mean(block_mean(r0, 1), row - 1, col, 1'b0);
        if (last_row) push_mean(block_mean(1, 1), row, col, 1'b1);
      end
    end
    col++;
    if (col >= n) begin
      col = 0;
      row++;
      if (row >= n) row = 0;
    end
    next_row = row;
    next_col = col;
  endtask

  task automatic check_result();
    mean_t want;
    if (pending_means.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat, data %h last %b",
                                m_axis_tdata, m_axis_tlast));
    end else begin
      want = pending_means.pop_front();
      if (m_axis_tdata[PIX_W-1:0] !== want.smoothed)
        report_mismatch($sformatf("(%0d,%0d) smoothed %0d, expected %0d", want.row,
                                  want.column, m_axis_tdata[PIX_W-1:0], want.smoothed));
      if (m_axis_tdata[ROW_LSB +: POS_W] !== want.row)
        report_mismatch($sformatf("row %0d, expected %0d",
                                  m_axis_tdata[ROW_LSB +: POS_W], want.row));
      if (m_axis_tdata[COL_LSB +: POS_W] !== want.column)
        report_mismatch($sformatf("column %0d, expected %0d",
                                  m_axis_tdata[COL_LSB +: POS_W], want.column));
      if (m_axis_tlast !== want.eoi)
        report_mismatch($sformatf("(%0d,%0d) tlast %b, expected %b", want.row, want.column,
                                  m_axis_tlast, want.eoi));
    end
  endtask

  // monitor: results first, then the pixel beat taken at this edge
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("box_filter_3x3_edge_average_top test failed");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        advance_window(s_axis_tdata);
        pixels_taken++;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // pixel driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tdata  <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // every queued pixel taken and every owed result seen
  task automatic wait_all_results();
    do @(negedge clk_i);
    while (pixels_taken != pixels_pushed || pending_means.size() != 0);
  endtask

  task automatic write_image_size(input int value);
    wait_all_results();
    // a pixel releasing nothing may still sit in the pipeline
    repeat (SETTLE) @(negedge clk_i);
    cfg_wdata_i <= SIZE_W'(value);
    cfg_we_i    <= 1'b1;
    size_reg = SIZE_W'(value);
    next_row = 0;
    next_col = 0;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixels(input logic [PIX_W-1:0] px []);
    @(posedge clk_i);
    foreach (px[i]) begin
      pixel_q.push_back(px[i]);
      pixels_pushed++;
    end
  endtask

  task automatic send_random(input int count);
    @(posedge clk_i);
    repeat (count) begin
      pixel_q.push_back(PIX_W'($urandom_range(0, 255)));
      pixels_pushed++;
    end
    rand_sent += count;
  endtask

  // whole images mostly, now and then a truncated one cut short by a size write
  task automatic random_images(input int upto);
    int side;
    while (rand_sent < upto) begin
      side = $urandom_range(2, 12);
      if ($urandom_range(0, 7) == 0) side = $urandom_range(13, 16);
      write_image_size(side);
      if ($urandom_range(0, 3) == 0) begin
        send_random($urandom_range(1, side * side - 1));
      end else begin
        repeat ($urandom_range(1, 2)) send_random(side * side);
      end
    end
  endtask

  initial begin
    size_reg = SIZE_W'(10);
    next_row = 0;
    next_col = 0;
    foreach (line_two_up[i]) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    foreach (win[c, r]) win[c][r] = '0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: sizes below the minimum act as 2, full-scale and mixed pixels
    write_image_size(0);
    send_pixels('{8'hff, 8'hff, 8'hff, 8'hff});
    write_image_size(1);
    send_pixels('{8'h00, 8'hff, 8'haa, 8'h55});
    write_image_size(3);
    send_pixels('{8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff});

    // size beyond the maximum acts as the maximum: a long first row releases nothing
    write_image_size(2047);
    send_random(24);
    rand_sent = 0;

    // sender idles 20 %, receiver 81 %
    random_images(80);

    // the other way round; once the sender waits for everything to drain mid-image
    @(posedge clk_i);
    tx_idle_pct = 81;
    rx_idle_pct = 20;
    write_image_size(6);
    send_random(18);
    wait_all_results();
    send_random(18);
    random_images(170);

    // no idling; one long receiver hold-off so the block backs up its input
    @(posedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_image_size(10);
    @(posedge clk_i);
    hold_asked++;
    send_random(100);
    random_images(260);

    wait_all_results();
    repeat (16) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("box_filter_3x3_edge_average_top test passed");
    end else begin
      $display("box_filter_3x3_edge_average_top test failed");
    end
    $finish;
  end

endmodule
